/* hw/rtl/sct_pkg.sv */
// ----------------------------------------------------------------------------
// sct_pkg: shared types and constants of the sorted capacity table
// Holds the record layout, the result codes, the command codes and the
// command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package sct_pkg;

	localparam int ID_W     = 64;
	localparam int STATUS_W = 3;
	localparam int CMD_W    = 2;

	localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_BUILD = 2'd1;
	localparam logic [CMD_W-1:0] CMD_FIND  = 2'd2;
	localparam logic [CMD_W-1:0] CMD_RSVD  = 2'd3;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 3'd0,
		ST_BOUND     = 3'd1,
		ST_ZERO_ID   = 3'd2,
		ST_DUP       = 3'd3,
		ST_ZERO_CAP  = 3'd4,
		ST_NOT_FOUND = 3'd5
	} status_t;

	typedef struct packed {
		logic [ID_W-1:0] id;
		logic [ID_W-1:0] cap;
		logic [ID_W-1:0] qlim;
		logic [ID_W-1:0] blim;
		logic            usable;
	} rec_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_CAPTURE,
		OP_ADD,
		OP_BUILD_BEGIN,
		OP_SORT_READ,
		OP_SORT_KEY,
		OP_SORT_CMP,
		OP_SORT_PUT,
		OP_CHK_START,
		OP_CHK_READ,
		OP_CHK_NEXT,
		OP_FND_START,
		OP_FND_READ,
		OP_FND_STEP
	} dp_op_t;

	typedef struct packed {
		dp_op_t  op;
		logic    set_res;
		status_t code;
		logic    take_hit;
		logic    set_built;
		logic    publish;
	} sct_cmd_t;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic             ovf;
		logic             built;
		logic             key_zero;
		logic             i_done;
		logic             j_last;
		logic             id_gt;
		logic             chk_zero;
		logic             chk_dup;
		logic             chk_cap;
		logic             lo_ge_hi;
		logic             fnd_eq;
		logic             out_free;
	} sct_sts_t;

endpackage

/* hw/rtl/sct_ram.sv */
// ----------------------------------------------------------------------------
// sct_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sct_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                                          clk,
	input  logic                                          we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                              wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                              rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* hw/rtl/sct_ctrl.sv */
// ----------------------------------------------------------------------------
// sct_ctrl: controller of the sorted capacity table
// Sequences add, insertion sort, validation scan and binary search.
// ----------------------------------------------------------------------------
module sct_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  sct_pkg::sct_sts_t sts_i,
	output sct_pkg::sct_cmd_t cmd_o
);
	import sct_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_SORT_READ,
		S_SORT_KEY,
		S_SORT_CMP,
		S_SORT_PUT,
		S_CHK_READ,
		S_CHK_EVAL,
		S_FND_READ,
		S_FND_EVAL,
		S_DONE
	} state_t;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd_o   = '0;
		cmd_o.op   = OP_NONE;
		cmd_o.code = ST_OK;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd_o.op = OP_CAPTURE;
					state_d  = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				case (sts_i.cmd)
					CMD_ADD: begin
						cmd_o.op      = OP_ADD;
						cmd_o.set_res = 1'b1;
						state_d       = S_DONE;
					end
					CMD_BUILD: begin
						cmd_o.op = OP_BUILD_BEGIN;
						if (sts_i.ovf) begin
							cmd_o.set_res = 1'b1;
							cmd_o.code    = ST_BOUND;
							state_d       = S_DONE;
						end else begin
							state_d = S_SORT_READ;
						end
					end
					CMD_FIND: begin
						if (!sts_i.built || sts_i.key_zero) begin
							cmd_o.set_res = 1'b1;
							cmd_o.code    = ST_NOT_FOUND;
							state_d       = S_DONE;
						end else begin
							cmd_o.op = OP_FND_START;
							state_d  = S_FND_READ;
						end
					end
					default: begin
						cmd_o.set_res = 1'b1;
						state_d       = S_DONE;
					end
				endcase
			end
			S_SORT_READ: begin
				if (sts_i.i_done) begin
					cmd_o.op = OP_CHK_START;
					state_d  = S_CHK_READ;
				end else begin
					cmd_o.op = OP_SORT_READ;
					state_d  = S_SORT_KEY;
				end
			end
			S_SORT_KEY: begin
				cmd_o.op = OP_SORT_KEY;
				state_d  = S_SORT_CMP;
			end
			S_SORT_CMP: begin
				cmd_o.op = OP_SORT_CMP;
				if (sts_i.id_gt) begin
					if (sts_i.j_last) begin
						state_d = S_SORT_PUT;
					end
				end else begin
					state_d = S_SORT_READ;
				end
			end
			S_SORT_PUT: begin
				cmd_o.op = OP_SORT_PUT;
				state_d  = S_SORT_READ;
			end
			S_CHK_READ: begin
				if (sts_i.i_done) begin
					cmd_o.set_res   = 1'b1;
					cmd_o.set_built = 1'b1;
					state_d         = S_DONE;
				end else begin
					cmd_o.op = OP_CHK_READ;
					state_d  = S_CHK_EVAL;
				end
			end
			S_CHK_EVAL: begin
				if (sts_i.chk_zero) begin
					cmd_o.set_res = 1'b1;
					cmd_o.code    = ST_ZERO_ID;
					state_d       = S_DONE;
				end else if (sts_i.chk_dup) begin
					cmd_o.set_res = 1'b1;
					cmd_o.code    = ST_DUP;
					state_d       = S_DONE;
				end else if (sts_i.chk_cap) begin
					cmd_o.set_res = 1'b1;
					cmd_o.code    = ST_ZERO_CAP;
					state_d       = S_DONE;
				end else begin
					cmd_o.op = OP_CHK_NEXT;
					state_d  = S_CHK_READ;
				end
			end
			S_FND_READ: begin
				if (sts_i.lo_ge_hi) begin
					cmd_o.set_res = 1'b1;
					cmd_o.code    = ST_NOT_FOUND;
					state_d       = S_DONE;
				end else begin
					cmd_o.op = OP_FND_READ;
					state_d  = S_FND_EVAL;
				end
			end
			S_FND_EVAL: begin
				if (sts_i.fnd_eq) begin
					cmd_o.set_res  = 1'b1;
					cmd_o.take_hit = 1'b1;
					state_d        = S_DONE;
				end else begin
					cmd_o.op = OP_FND_STEP;
					state_d  = S_FND_READ;
				end
			end
			S_DONE: begin
				if (sts_i.out_free) begin
					cmd_o.publish = 1'b1;
					state_d       = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

/* hw/rtl/sct_dp.sv */
// ----------------------------------------------------------------------------
// sct_dp: datapath of the sorted capacity table
// Record memory, counters, comparators and the result registers.
// ----------------------------------------------------------------------------
module sct_dp #(
	parameter int MAX_ENTRIES = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [sct_pkg::CMD_W-1:0]       command,
	input  logic [sct_pkg::ID_W-1:0]        resource_id,
	input  logic [sct_pkg::ID_W-1:0]        capacity,
	input  logic [sct_pkg::ID_W-1:0]        queue_limit,
	input  logic [sct_pkg::ID_W-1:0]        buffer_limit,
	input  logic                            usable,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [sct_pkg::STATUS_W-1:0]    status,
	output logic                            found,
	output logic [sct_pkg::ID_W-1:0]        found_capacity,
	output logic [sct_pkg::ID_W-1:0]        found_queue_limit,
	output logic [sct_pkg::ID_W-1:0]        found_buffer_limit,
	output logic                            found_usable,
	input  sct_pkg::sct_cmd_t               cmd_i,
	output sct_pkg::sct_sts_t               sts_o
);
	import sct_pkg::*;

	localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ENTRIES);

	logic [CW-1:0]    cnt_q;
	logic             ovf_q;
	logic             built_q;
	logic             out_valid_q;
	rec_t             in_rec_q;
	logic [CMD_W-1:0] cmd_q;
	rec_t             key_q;
	logic [CW-1:0]    i_q;
	logic [CW-1:0]    j_q;
	logic [CW-1:0]    lo_q;
	logic [CW-1:0]    hi_q;
	logic [ID_W-1:0]  prev_q;
	status_t          res_st_q;
	logic             res_hit_q;
	rec_t             res_rec_q;
	status_t          out_st_q;
	logic             out_hit_q;
	rec_t             out_rec_q;

	logic             ram_we;
	logic [AW-1:0]    ram_waddr;
	rec_t             ram_wdata;
	logic [AW-1:0]    ram_raddr;
	logic [$bits(rec_t)-1:0] ram_rdata;
	rec_t             rd_rec;
	logic             full;
	logic             id_gt;
	logic [CW-1:0]    i_m1;
	logic [CW-1:0]    j_m2;
	logic [CW:0]      lo_hi_sum;
	logic [CW-1:0]    mid;

	assign rd_rec    = rec_t'(ram_rdata);
	assign full      = (cnt_q == MAX_CNT);
	assign id_gt     = (rd_rec.id > key_q.id);
	assign i_m1      = i_q - CW'(1);
	assign j_m2      = j_q - CW'(2);
	assign lo_hi_sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid       = lo_hi_sum[CW:1];

	sct_ram #(
		.WIDTH ($bits(rec_t)),
		.DEPTH (MAX_ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = j_q[AW-1:0];
		ram_wdata = key_q;
		ram_raddr = i_q[AW-1:0];
		case (cmd_i.op)
			OP_ADD: begin
				ram_we    = !full;
				ram_waddr = cnt_q[AW-1:0];
				ram_wdata = in_rec_q;
			end
			OP_SORT_KEY: begin
				ram_raddr = i_m1[AW-1:0];
			end
			OP_SORT_CMP: begin
				ram_we = 1'b1;
				if (id_gt) begin
					ram_wdata = rd_rec;
					ram_raddr = j_m2[AW-1:0];
				end
			end
			OP_SORT_PUT: begin
				ram_we = 1'b1;
			end
			OP_FND_READ: begin
				ram_raddr = mid[AW-1:0];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			ovf_q       <= 1'b0;
			built_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd_i.op == OP_ADD) begin
				built_q <= 1'b0;
				if (full) begin
					ovf_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + CW'(1);
				end
			end
			if (cmd_i.op == OP_BUILD_BEGIN) begin
				built_q <= 1'b0;
			end
			if (cmd_i.set_built) begin
				built_q <= 1'b1;
			end
			if (cmd_i.publish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (cmd_i.op)
			OP_CAPTURE: begin
				cmd_q    <= command;
				in_rec_q <= '{id: resource_id, cap: capacity,
					qlim: queue_limit, blim: buffer_limit, usable: usable};
			end
			OP_BUILD_BEGIN: begin
				i_q <= CW'(1);
			end
			OP_SORT_KEY: begin
				key_q <= rd_rec;
				j_q   <= i_q;
			end
			OP_SORT_CMP: begin
				if (id_gt) begin
					j_q <= j_q - CW'(1);
				end else begin
					i_q <= i_q + CW'(1);
				end
			end
			OP_SORT_PUT: begin
				i_q <= i_q + CW'(1);
			end
			OP_CHK_START: begin
				i_q <= '0;
			end
			OP_CHK_NEXT: begin
				prev_q <= rd_rec.id;
				i_q    <= i_q + CW'(1);
			end
			OP_FND_START: begin
				lo_q <= '0;
				hi_q <= cnt_q;
			end
			OP_FND_READ: begin
				i_q <= mid;
			end
			OP_FND_STEP: begin
				if (rd_rec.id < in_rec_q.id) begin
					lo_q <= i_q + CW'(1);
				end else begin
					hi_q <= i_q;
				end
			end
			default: begin
			end
		endcase
		if (cmd_i.set_res) begin
			res_st_q  <= cmd_i.code;
			res_hit_q <= cmd_i.take_hit;
			res_rec_q <= cmd_i.take_hit ? rd_rec : '0;
		end
		if (cmd_i.publish) begin
			out_st_q  <= res_st_q;
			out_hit_q <= res_hit_q;
			out_rec_q <= res_rec_q;
		end
	end

	always_comb begin
		sts_o          = '0;
		sts_o.cmd      = cmd_q;
		sts_o.ovf      = ovf_q;
		sts_o.built    = built_q;
		sts_o.key_zero = (in_rec_q.id == '0);
		sts_o.i_done   = (i_q >= cnt_q);
		sts_o.j_last   = (j_q == CW'(1));
		sts_o.id_gt    = id_gt;
		sts_o.chk_zero = (rd_rec.id == '0);
		sts_o.chk_dup  = (i_q != '0) && (rd_rec.id == prev_q);
		sts_o.chk_cap  = (rd_rec.cap == '0) && rd_rec.usable;
		sts_o.lo_ge_hi = (lo_q >= hi_q);
		sts_o.fnd_eq   = (rd_rec.id == in_rec_q.id);
		sts_o.out_free = !out_valid_q || out_ready;
	end

	assign out_valid          = out_valid_q;
	assign status             = out_st_q;
	assign found              = out_hit_q;
	assign found_capacity     = out_rec_q.cap;
	assign found_queue_limit  = out_rec_q.qlim;
	assign found_buffer_limit = out_rec_q.blim;
	assign found_usable       = out_rec_q.usable;

`ifndef SYNTH
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= MAX_CNT)
		else $error("record count beyond table depth");
	a_built_no_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		built_q |-> !ovf_q)
		else $error("table marked built after an overflow");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_i.publish |-> (!out_valid_q || out_ready))
		else $error("result published over a pending transaction");
	a_hit_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_hit_q) |-> (out_st_q == ST_OK))
		else $error("match reported with a failing status");
	a_add_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_i.op == OP_ADD) |=> !built_q)
		else $error("built mark survived an add");
`endif

endmodule

/* hw/rtl/sorted_capacity_table.sv */
// ----------------------------------------------------------------------------
// sorted_capacity_table: sorted table of resource capacity records
// Add, build (sort and validate) and find on up to MAX_ENTRIES records.
// ----------------------------------------------------------------------------
// Usage. The input channel (in_valid, in_ready) carries one transaction per
// command: add a record, build and validate the table, or find a record by
// its id. Each input transaction yields exactly one transaction on the
// output channel (out_valid, out_ready) with a status and, for a hit, the
// record's fields. The block works on one transaction at a time; in_ready
// is high only while the controller is idle.
// Sequencing. A find is answered without a search when the table is not
// built or the id is zero, else by a binary search over the records.
// A build runs an insertion sort on the single-read record memory and
// then a validation scan of the sorted records.
// Reset clears the record count, the overflow flag and the built mark; the
// record memory is not cleared since only written entries are ever read.
// A stalled receiver holds the result in the output register; the next
// transaction is accepted and processed meanwhile and waits for that
// register to drain before its result is presented.
// ----------------------------------------------------------------------------
module sorted_capacity_table #(
	parameter int MAX_ENTRIES = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [sct_pkg::CMD_W-1:0]    command,
	input  logic [sct_pkg::ID_W-1:0]     resource_id,
	input  logic [sct_pkg::ID_W-1:0]     capacity,
	input  logic [sct_pkg::ID_W-1:0]     queue_limit,
	input  logic [sct_pkg::ID_W-1:0]     buffer_limit,
	input  logic                         usable,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [sct_pkg::STATUS_W-1:0] status,
	output logic                         found,
	output logic [sct_pkg::ID_W-1:0]     found_capacity,
	output logic [sct_pkg::ID_W-1:0]     found_queue_limit,
	output logic [sct_pkg::ID_W-1:0]     found_buffer_limit,
	output logic                         found_usable
);
	import sct_pkg::*;

	// Command and status bundles between the controller and the datapath.
	sct_cmd_t cmd;
	sct_sts_t sts;

	// The controller steps through the phases of each transaction.
	sct_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts_i    (sts),
		.cmd_o    (cmd)
	);

	// The datapath owns the record memory and the output register.
	sct_dp #(
		.MAX_ENTRIES (MAX_ENTRIES)
	) u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.command            (command),
		.resource_id        (resource_id),
		.capacity           (capacity),
		.queue_limit        (queue_limit),
		.buffer_limit       (buffer_limit),
		.usable             (usable),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.status             (status),
		.found              (found),
		.found_capacity     (found_capacity),
		.found_queue_limit  (found_queue_limit),
		.found_buffer_limit (found_buffer_limit),
		.found_usable       (found_usable),
		.cmd_i              (cmd),
		.sts_o              (sts)
	);

endmodule

/* tb/tb_sorted_capacity_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_capacity_table: self-checking bench for the sorted capacity table
// Drives add, build and find transactions with random gaps and receiver
// stalls, predicts every result from an independent model of the record
// table and compares each output transaction field by field, in order.
// ----------------------------------------------------------------------------
module tb_sorted_capacity_table;
	import sct_pkg::*;

	localparam int TABLE_DEPTH = 64;
	localparam int CYCLE_LIMIT = 4000000;

	typedef struct {
		logic [STATUS_W-1:0] st;
		logic                hit;
		logic [ID_W-1:0]     cap;
		logic [ID_W-1:0]     qlim;
		logic [ID_W-1:0]     blim;
		logic                usb;
	} answer_t;

	// Table predictor plus the queue of answers still owed by the block.
	class capacity_table_scoreboard;
		rec_t      recs[TABLE_DEPTH];
		int        count;
		bit        overflow;
		bit        built;
		answer_t   owed[$];
		int        errors;

		function void clear();
			count = 0;
			overflow = 0;
			built = 0;
			errors = 0;
			owed.delete();
		endfunction

		function logic [STATUS_W-1:0] build_table();
			rec_t key;
			int   j;
			built = 0;
			if (overflow)
				return ST_BOUND;
			// Stable insertion sort on id.
			for (int i = 1; i < count; i++) begin
				key = recs[i];
				j = i;
				while (j > 0 && recs[j-1].id > key.id) begin
					recs[j] = recs[j-1];
					j--;
				end
				recs[j] = key;
			end
			for (int i = 0; i < count; i++) begin
				if (recs[i].id == 0)
					return ST_ZERO_ID;
				if (i > 0 && recs[i].id == recs[i-1].id)
					return ST_DUP;
				if (recs[i].cap == 0 && recs[i].usable)
					return ST_ZERO_CAP;
			end
			built = 1;
			return ST_OK;
		endfunction

		function void note_input(logic [CMD_W-1:0] cmd, rec_t r);
			answer_t a;
			a = '{ST_OK, 0, 0, 0, 0, 0};
			if (cmd == CMD_ADD) begin
				built = 0;
				if (count < TABLE_DEPTH) begin
					recs[count] = r;
					count++;
				end else begin
					overflow = 1;
				end
			end else if (cmd == CMD_BUILD) begin
				a.st = build_table();
			end else if (cmd == CMD_FIND) begin
				a.st = ST_NOT_FOUND;
				if (built && r.id != 0) begin
					for (int i = 0; i < count; i++) begin
						if (recs[i].id == r.id) begin
							a = '{ST_OK, 1, recs[i].cap, recs[i].qlim,
								recs[i].blim, recs[i].usable};
							break;
						end
					end
				end
			end
			owed.insert(owed.size(), a);
		endfunction

		function void check_result(answer_t got);
			answer_t e;
			if (owed.size() == 0) begin
				$error("unexpected result, status %0d", got.st);
				errors++;
				return;
			end
			e = owed.pop_front();
			if (got.st !== e.st) begin
				$error("status: expected %0d, actual %0d", e.st, got.st);
				errors++;
			end
			if (got.hit !== e.hit) begin
				$error("found: expected %0d, actual %0d", e.hit, got.hit);
				errors++;
			end
			if (got.cap !== e.cap) begin
				$error("found_capacity: expected %h, actual %h", e.cap, got.cap);
				errors++;
			end
			if (got.qlim !== e.qlim) begin
				$error("found_queue_limit: expected %h, actual %h", e.qlim, got.qlim);
				errors++;
			end
			if (got.blim !== e.blim) begin
				$error("found_buffer_limit: expected %h, actual %h", e.blim, got.blim);
				errors++;
			end
			if (got.usb !== e.usb) begin
				$error("found_usable: expected %0d, actual %0d", e.usb, got.usb);
				errors++;
			end
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	logic [CMD_W-1:0]    command;
	logic [ID_W-1:0]     resource_id;
	logic [ID_W-1:0]     capacity;
	logic [ID_W-1:0]     queue_limit;
	logic [ID_W-1:0]     buffer_limit;
	logic                usable;
	logic                out_valid;
	logic                out_ready;
	logic [STATUS_W-1:0] status;
	logic                found;
	logic [ID_W-1:0]     found_capacity;
	logic [ID_W-1:0]     found_queue_limit;
	logic [ID_W-1:0]     found_buffer_limit;
	logic                found_usable;

	capacity_table_scoreboard sb;
	// Idle percentage for each side; zero during the calm stretch.
	int  send_idle_pct;
	int  recv_idle_pct;
	// Long receiver hold-off requested by the stimulus process.
	int  recv_hold;
	int  cycle_count;
	// Ids already added in the current table, for well-formed finds.
	logic [ID_W-1:0] known_ids[$];

	sorted_capacity_table #(.MAX_ENTRIES(TABLE_DEPTH)) u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.command(command), .resource_id(resource_id),
		.capacity(capacity), .queue_limit(queue_limit),
		.buffer_limit(buffer_limit), .usable(usable),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .found(found), .found_capacity(found_capacity),
		.found_queue_limit(found_queue_limit),
		.found_buffer_limit(found_buffer_limit), .found_usable(found_usable)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	function automatic logic [ID_W-1:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// Field values weighted toward zero, all-ones and small numbers.
	function automatic logic [ID_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2, 3: return ID_W'($urandom_range(1, 40));
			default: return rand64();
		endcase
	endfunction

	// Offers one transaction at the falling edge, holding it until accepted.
	// Valid stays up until the next falling edge, where the next send or a
	// drain takes it over.
	task automatic send(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] id,
		logic [ID_W-1:0] cap, logic [ID_W-1:0] ql, logic [ID_W-1:0] bl,
		logic u);
		rec_t r;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		command      <= cmd;
		resource_id  <= id;
		capacity     <= cap;
		queue_limit  <= ql;
		buffer_limit <= bl;
		usable       <= u;
		in_valid     <= 1'b1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		r = '{id: id, cap: cap, qlim: ql, blim: bl, usable: u};
		sb.note_input(cmd, r);
		if (cmd == CMD_ADD)
			known_ids.insert(known_ids.size(), id);
		@(negedge clk);
	endtask

	task automatic add_rec(logic [ID_W-1:0] id);
		send(CMD_ADD, id, pick_value(), pick_value(), pick_value(),
			1'($urandom_range(0, 1)));
	endtask

	task automatic find_id(logic [ID_W-1:0] id);
		send(CMD_FIND, id, rand64(), rand64(), rand64(), 1'($urandom_range(0, 1)));
	endtask

	// Sender pause until the block owes nothing.
	task automatic drain();
		in_valid <= 1'b0;
		@(negedge clk);
		while (sb.owed.size() != 0)
			@(negedge clk);
	endtask

	// Only a reset empties the table, so every table after the first is
	// built up from the leftovers; this keeps build counts and ids varied.
	task automatic random_table_session(int nrecs);
		logic [ID_W-1:0] base;
		base = ID_W'($urandom_range(1, 1000)) << $urandom_range(0, 50);
		for (int i = 0; i < nrecs; i++) begin
			// Mostly distinct ids; now and then a duplicate, zero or a bad capacity.
			case ($urandom_range(0, 29))
				0: add_rec('0);
				1: if (known_ids.size() != 0)
					add_rec(known_ids[$urandom_range(0, known_ids.size()-1)]);
				else
					add_rec(base + i);
				2: send(CMD_ADD, base + i * 7 + 1, '0, rand64(), rand64(), 1'b1);
				default: add_rec(base + ID_W'($urandom_range(0, 2000)) * 3 + i);
			endcase
		end
		send(CMD_BUILD, rand64(), rand64(), rand64(), rand64(),
			1'($urandom_range(0, 1)));
		for (int k = 0; k < 2 * nrecs + 4; k++) begin
			case ($urandom_range(0, 5))
				0: find_id(rand64());
				1: find_id('0);
				default: if (known_ids.size() != 0)
					find_id(known_ids[$urandom_range(0, known_ids.size()-1)]);
				else
					find_id(base);
			endcase
		end
	endtask

	// Receiver: random stalls plus a long hold-off when asked.
	always @(negedge clk) begin
		if (recv_hold > 0) begin
			out_ready <= 1'b0;
			recv_hold <= recv_hold - 1;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// Output sampling at the rising edge.
	always @(posedge clk) begin
		answer_t got;
		if (arst_n && out_valid && out_ready) begin
			got = '{status, found, found_capacity, found_queue_limit,
				found_buffer_limit, found_usable};
			sb.check_result(got);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		int sent_items;
		sb = new();
		sb.clear();
		cycle_count = 0;
		send_idle_pct = 28;
		recv_idle_pct = 28;
		recv_hold = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		out_ready = 1'b0;
		command = CMD_ADD;
		resource_id = '0;
		capacity = '0;
		queue_limit = '0;
		buffer_limit = '0;
		usable = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: empty build, finds before build, unused command, extremes.
		find_id(64'd5);
		send(CMD_BUILD, '0, '0, '0, '0, 1'b0);
		find_id(64'd5);
		send(CMD_RSVD, '1, '1, '1, '1, 1'b1);
		send(CMD_ADD, '1, '1, '1, '1, 1'b1);
		send(CMD_ADD, 64'd3, 64'd9, '0, '1, 1'b0);
		send(CMD_ADD, 64'd2, '0, 64'd4, 64'd8, 1'b0);
		find_id(64'd3);
		send(CMD_BUILD, '0, '0, '0, '0, 1'b0);
		find_id('1);
		find_id(64'd2);
		find_id('0);
		find_id(64'd4);
		// Zero capacity on a usable record.
		send(CMD_ADD, 64'd7, '0, 64'd1, 64'd1, 1'b1);
		send(CMD_BUILD, '0, '0, '0, '0, 1'b0);
		find_id(64'd3);
		// Duplicate id, then a zero id which sorts first and wins.
		send(CMD_ADD, 64'd3, 64'd1, 64'd1, 64'd1, 1'b0);
		send(CMD_BUILD, '0, '0, '0, '0, 1'b0);
		send(CMD_ADD, '0, 64'd1, 64'd1, 64'd1, 1'b0);
		send(CMD_BUILD, '0, '0, '0, '0, 1'b0);

		// Long receiver hold-off while the sender keeps going.
		drain();
		recv_hold = 300;
		for (int i = 0; i < 8; i++)
			find_id(64'd3);
		drain();

		// Random sessions; first a calm stretch with no idling.
		sent_items = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		while (sent_items < 1350) begin
			int n;
			if (sent_items > 200) begin
				send_idle_pct = 28;
				recv_idle_pct = 28;
			end
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
			// The table never shrinks, so sessions stay small; overflow comes late.
			if (sb.count + n > 60 && sent_items < 1100)
				n = (60 > sb.count) ? 60 - sb.count : 0;
			random_table_session(n);
			sent_items += 3 * n + 5;
			if ($urandom_range(0, 9) == 0)
				drain();
		end

		// Overflow: fill past capacity; every later build reports it.
		while (sb.count < TABLE_DEPTH)
			add_rec(rand64());
		add_rec(rand64());
		send(CMD_BUILD, '0, '0, '0, '0, 1'b0);
		find_id(known_ids[0]);
		random_table_session(10);

		drain();
		repeat (200) @(posedge clk);
		if (sb.errors == 0 && sb.owed.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end
endmodule
